// ===== rtl/fopq_pkg.sv =====
`timescale 1ns / 1ps
package fopq_pkg;

  localparam int ENTRY_W = 16;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic MODE_FCFS = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  localparam logic [1:0] ST_PUSHED    = 2'd0;
  localparam logic [1:0] ST_POPPED    = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY = 2'd2;
  localparam logic [1:0] ST_PUSH_FULL = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT,
    S_SH_WR,
    S_POP_RD,
    S_POP_DAT,
    S_RESP
  } fopq_state_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } fopq_entry_t;

endpackage

// ===== rtl/fopq_ram.sv =====
`timescale 1ns / 1ps
module fopq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fcfs_or_priority_ready_queue_core.sv =====
`timescale 1ns / 1ps
// Pop reads the head entry; FCFS push writes at the tail; priority push scans the stored
// entries in order, then moves each later entry back one place before writing the new one.
// Pop on empty or push on full goes straight to the response. One word is in flight at a time.
// Each step is one access to the single-port entry RAM (registered read).
// in_ready is low from accept until the result is loaded, longer while a result waits.
// Synchronous active-low reset empties the queue and sets FCFS order; RAM not cleared.
module fcfs_or_priority_ready_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_process_id,
  input  logic [7:0] in_priority_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_process_id,
  output logic [7:0] out_priority,
  output logic [4:0] out_occupancy
);
  import fopq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fopq_state_t state_r, state_nxt;

  logic          mode_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          kind_r;
  logic [7:0]    pid_r;
  logic [7:0]    prio_r;
  logic [1:0]    res_status_r, res_status_nxt;
  fopq_entry_t   res_ent_r, res_ent_nxt;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  fopq_entry_t   out_ent_r;
  logic [4:0]    out_occ_r;
  logic          load_out;

  logic [CW-1:0] off;
  logic [AW:0]   addr_sum;
  logic [AW-1:0] addr;
  logic          we;
  fopq_entry_t   wdata;
  logic [ENTRY_W-1:0] rdata_raw;
  fopq_entry_t   rdata;
  logic          accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign rdata     = fopq_entry_t'(rdata_raw);

  // shared address unit: logical offset from head, wrapped to DEPTH
  always_comb begin
    off = idx_r;
    if (state_r == S_POP_RD) begin
      off = '0;
    end else if (state_r == S_SHIFT && idx_r != pos_r) begin
      off = idx_r - CW'(1);
    end
    addr_sum = {1'b0, head_r} + (AW + 1)'(off);
    if (addr_sum >= (AW + 1)'(DEPTH)) begin
      addr_sum = addr_sum - (AW + 1)'(DEPTH);
    end
    addr = addr_sum[AW-1:0];
  end

  fopq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_FCFS;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    if (accept) begin
      kind_r <= in_kind;
      pid_r  <= in_process_id;
      prio_r <= in_priority_req;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_ent_r    <= res_ent_r;
      out_occ_r    <= 5'(count_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    we             = 1'b0;
    wdata          = rdata;
    load_out       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_ent_nxt = '0;
          if (in_kind == KIND_POP) begin
            if (count_r == '0) begin
              res_status_nxt = ST_POP_EMPTY;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_POP_RD;
            end
          end else if (count_r == CW'(DEPTH)) begin
            res_status_nxt = ST_PUSH_FULL;
            state_nxt      = S_RESP;
          end else if (mode_r == MODE_PRIO && count_r != '0) begin
            idx_nxt   = '0;
            state_nxt = S_SCAN_RD;
          end else begin
            pos_nxt   = count_r;
            idx_nxt   = count_r;
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (prio_r < rdata.prio) begin
          pos_nxt   = idx_r;
          idx_nxt   = count_r;
          state_nxt = S_SHIFT;
        end else if (idx_r + CW'(1) == count_r) begin
          pos_nxt   = count_r;
          idx_nxt   = count_r;
          state_nxt = S_SHIFT;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT: begin
        if (idx_r == pos_r) begin
          we             = 1'b1;
          wdata.id       = pid_r;
          wdata.prio     = prio_r;
          count_nxt      = count_r + CW'(1);
          res_status_nxt = ST_PUSHED;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        we        = 1'b1;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = S_SHIFT;
      end
      S_POP_RD: begin
        state_nxt = S_POP_DAT;
      end
      S_POP_DAT: begin
        res_ent_nxt    = rdata;
        res_status_nxt = ST_POPPED;
        count_nxt      = count_r - CW'(1);
        head_nxt       = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_process_id = out_ent_r.id;
  assign out_priority   = out_ent_r.prio;
  assign out_occupancy  = out_occ_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("queue ready again right after accept");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_DAT |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not drop one entry");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_POP_EMPTY |-> out_occ_r == 5'd0)
    else $error("pop on empty with nonzero occupancy");

  a_kind_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> kind_r == KIND_PUSH)
    else $error("shift walk on a pop word");

endmodule
